[hdl/oram_bucket_slot_tracker_assert.svh]
// Assertion macros used by the checker file of the bucket tracker.
`ifndef ORAM_BUCKET_SLOT_TRACKER_ASSERT_SVH
`define ORAM_BUCKET_SLOT_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBST_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bucket tracker check failed");

// The consequent must hold in the cycle after the antecedent.
`define OBST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bucket tracker check failed");

`endif

[hdl/obst_pkg.sv]
package obst_pkg;

	// Tree geometry.
	localparam int MAX_LEVELS = 10;
	localparam int NBUCKETS = (1 << MAX_LEVELS) - 1;
	localparam int BKT_W = MAX_LEVELS;
	localparam int LEAF_W = 9;
	localparam int LEVEL_W = 4;

	// Bucket contents.
	localparam int SLOTS = 8;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int ID_W = 21;
	localparam int CNT_W = 8;
	localparam logic [ID_W-1:0] DUMMY_ID = {ID_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_TREE_LEVELS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DUMMY_SLOTS = CFG_IDX_W'(1);
	localparam logic [LEVEL_W-1:0] TREE_LEVELS_RST = LEVEL_W'(10);
	localparam logic [CNT_W-1:0] DUMMY_SLOTS_RST = CNT_W'(4);

	// Queue between front and back (depth is a power of two).
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		ACT_TOUCH = 3'd0,
		ACT_TAKE  = 3'd1,
		ACT_PEEK  = 3'd2,
		ACT_WRITE = 3'd3,
		ACT_RESET = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	// One classified request as it waits in the queue.
	typedef struct packed {
		logic [2:0]        action;
		logic [BKT_W-1:0]  bucket;
		logic              bad_level;
		logic [ID_W-1:0]   req_id;
		logic [SLOT_W-1:0] sel;
	} entry_t;

	// One row of the bucket memory.
	typedef struct packed {
		logic [SLOTS-1:0][ID_W-1:0] ids;
		logic [SLOTS-1:0]           valid;
		logic [CNT_W-1:0]           visits;
	} row_t;

	localparam row_t RESET_ROW = '{
		ids:    {SLOTS{DUMMY_ID}},
		valid:  {SLOTS{1'b1}},
		visits: '0
	};

	typedef struct packed {
		logic [BKT_W-1:0]  bucket_index;
		logic [SLOT_W-1:0] slot_offset;
		logic              real_hit;
		logic              no_slot;
		logic              reshuffle_needed;
		logic [CNT_W-1:0]  visit_count;
	} result_t;

	// Status the back part reports to the front part.
	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

[hdl/obst_if.sv]
// Request channel.
interface obst_in_if import obst_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [2:0]                action;
	logic [LEAF_W-1:0]         leaf_index;
	logic [LEVEL_W-1:0]        tree_level;
	logic signed [ID_W-1:0]    request_id;
	logic [SLOT_W-1:0]         slot_select;

	modport source (output valid, action, leaf_index, tree_level, request_id, slot_select,
		input ready);
	modport sink (input valid, action, leaf_index, tree_level, request_id, slot_select,
		output ready);
endinterface

// Result channel.
interface obst_out_if import obst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BKT_W-1:0]  bucket_index;
	logic [SLOT_W-1:0] slot_offset;
	logic              real_hit;
	logic              no_slot;
	logic              reshuffle_needed;
	logic [CNT_W-1:0]  visit_count;

	modport source (output valid, bucket_index, slot_offset, real_hit, no_slot,
		reshuffle_needed, visit_count, input ready);
	modport sink (input valid, bucket_index, slot_offset, real_hit, no_slot,
		reshuffle_needed, visit_count, output ready);
endinterface

// Configuration write channel.
interface obst_cfg_if import obst_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/obst_queue.sv]
module obst_queue import obst_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output entry_t pop_data,
	output logic   not_empty,
	output logic   full
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign not_empty = (count_q != '0);
	assign full = (count_q == (QPTR_W+1)'(QDEPTH));
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap naturally since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/obst_front.sv]
module obst_front import obst_pkg::*; (
	obst_in_if.sink            item,
	input  logic [LEVEL_W-1:0] tree_levels,
	input  back_status_t       status,
	input  logic               q_full,
	output logic               q_push,
	output entry_t             q_entry
);

	logic [LEVEL_W-1:0] levels;
	logic [LEVEL_W-1:0] shift;
	logic [LEAF_W-1:0]  leaf_mask;
	logic [LEAF_W-1:0]  leaf_m;

	// Requests are held off while the bucket memory is being cleared.
	assign item.ready = !q_full && !status.clearing;
	assign q_push = item.valid && item.ready;

	// Locate the bucket on the leaf's path.
	always_comb begin
		levels = (tree_levels > LEVEL_W'(MAX_LEVELS)) ? LEVEL_W'(MAX_LEVELS) : tree_levels;
		shift = levels - item.tree_level - 1'b1;
		leaf_mask = ~({LEAF_W{1'b1}} << (levels - 1'b1));
		leaf_m = item.leaf_index & leaf_mask;

		q_entry.action = item.action;
		q_entry.bad_level = (item.tree_level >= levels);
		q_entry.bucket = ((BKT_W'(1) << item.tree_level) - 1'b1) + BKT_W'(leaf_m >> shift);
		q_entry.req_id = item.request_id;
		q_entry.sel = item.slot_select;
	end

endmodule

[hdl/obst_back.sv]
module obst_back import obst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  entry_t           q_entry,
	output logic             q_pop,
	input  logic [CNT_W-1:0] dummy_slots,
	output back_status_t     status,
	output logic             res_valid,
	output result_t          res_data,
	input  logic             res_ready
);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [BKT_W-1:0]  clr_idx_q;
	row_t              mem_q [NBUCKETS];
	row_t              row_s1;
	entry_t            ent_q;
	logic              rd_en;
	logic              we;
	logic [BKT_W-1:0]  waddr;
	row_t              wdata;
	logic              load_res;
	logic              out_free;
	logic              res_valid_q;
	result_t           res_q;
	row_t              upd_row;
	logic              upd_we;
	result_t           res_d;
	logic [SLOTS-1:0]  match;
	logic [SLOTS-1:0]  dmatch;
	logic              found;
	logic              dfound;
	logic [SLOT_W-1:0] pick;
	logic [SLOT_W-1:0] dpick;

	assign status.clearing = (state_q == BK_CLEAR);
	assign out_free = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res_data = res_q;

	// Bucket memory: one row write and one registered row read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_s1 <= mem_q[q_entry.bucket];
			ent_q <= q_entry;
		end
	end

	// State register and clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// Sequencer: clear every row, then read a row per request and write it back when the request changes it.
	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		rd_en = 1'b0;
		we = 1'b0;
		waddr = clr_idx_q;
		wdata = RESET_ROW;
		load_res = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				we = 1'b1;
				if (clr_idx_q == BKT_W'(NBUCKETS - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					rd_en = 1'b1;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (out_free) begin
					load_res = 1'b1;
					we = upd_we;
					waddr = ent_q.bucket;
					wdata = upd_row;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Slot lookup: lowest valid slot holding the id, else lowest valid dummy.
	always_comb begin
		found = 1'b0;
		dfound = 1'b0;
		pick = '0;
		dpick = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			match[i] = row_s1.valid[i] && (row_s1.ids[i] == ent_q.req_id);
			dmatch[i] = row_s1.valid[i] && (row_s1.ids[i] == DUMMY_ID);
			if (match[i]) begin
				found = 1'b1;
				pick = SLOT_W'(i);
			end
			if (dmatch[i]) begin
				dfound = 1'b1;
				dpick = SLOT_W'(i);
			end
		end
	end

	// Row update and result for the request in flight.
	always_comb begin
		upd_row = row_s1;
		upd_we = 1'b0;
		res_d = '0;
		res_d.bucket_index = ent_q.bucket;
		case (ent_q.action)
			ACT_TOUCH: begin
				if (row_s1.visits != CNT_MAX) begin
					upd_row.visits = row_s1.visits + 1'b1;
				end
				upd_we = 1'b1;
			end
			ACT_TAKE, ACT_PEEK: begin
				if (found) begin
					res_d.slot_offset = pick;
					res_d.real_hit = (ent_q.req_id != DUMMY_ID);
				end else if (dfound) begin
					res_d.slot_offset = dpick;
				end else begin
					res_d.no_slot = 1'b1;
				end
				if ((found || dfound) && (ent_q.action == ACT_TAKE)) begin
					upd_row.valid[res_d.slot_offset] = 1'b0;
					upd_we = 1'b1;
				end
			end
			ACT_WRITE: begin
				// The slot field spans exactly the slots of a bucket.
				upd_row.ids[ent_q.sel] = ent_q.req_id;
				res_d.slot_offset = ent_q.sel;
				upd_we = 1'b1;
			end
			ACT_RESET: begin
				upd_row.visits = '0;
				upd_row.valid = {SLOTS{1'b1}};
				upd_we = 1'b1;
			end
			default: begin
				res_d.no_slot = 1'b1;
			end
		endcase
		res_d.visit_count = upd_row.visits;
		res_d.reshuffle_needed = (upd_row.visits >= dummy_slots);

		// A level off the tree touches nothing and reports only no_slot.
		if (ent_q.bad_level) begin
			upd_we = 1'b0;
			res_d = '0;
			res_d.no_slot = 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= res_d;
		end
	end

endmodule

[hdl/oram_bucket_slot_tracker.sv]
// Bucket metadata engine for a tree-shaped oblivious store.
// Requests enter on the item channel (valid/ready): an action, a leaf and
// a level that pick one bucket, a block id and a slot number. Each request
// gives exactly one result on the result channel (valid/ready), in order.
// The cfg channel writes the tree_levels and dummy_slots registers; it is
// always ready and should be used only while no request is in flight.
// In the back end a request first has its bucket row read into a register
// from the single-port-write row memory, then the row is updated, written
// back where the action changes it, and the result register is loaded;
// only then does the back end take the next request from the queue.
// A two-entry queue lets the item channel keep accepting while the back
// end works or waits; when the receiver stalls the result register holds
// its value and the queue fills, after which item.ready drops.
// After reset the row memory is cleared one bucket per cycle through all
// 1023 buckets, and item.ready stays low until that pass is over;
// configuration writes are taken throughout.
module oram_bucket_slot_tracker import obst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	obst_in_if.sink     item,
	obst_out_if.source  result,
	obst_cfg_if.sink    cfg
);

	logic [LEVEL_W-1:0] tree_levels_q;
	logic [CNT_W-1:0]   dummy_slots_q;
	back_status_t       status;
	logic               q_push;
	entry_t             q_in;
	logic               q_pop;
	entry_t             q_out;
	logic               q_not_empty;
	logic               q_full;
	logic               res_valid;
	result_t            res_data;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_levels_q <= TREE_LEVELS_RST;
			dummy_slots_q <= DUMMY_SLOTS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TREE_LEVELS: tree_levels_q <= cfg.data[LEVEL_W-1:0];
				REG_DUMMY_SLOTS: dummy_slots_q <= cfg.data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	obst_front u_front (
		.item        (item),
		.tree_levels (tree_levels_q),
		.status      (status),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_in)
	);

	obst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	obst_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_not_empty),
		.q_entry     (q_out),
		.q_pop       (q_pop),
		.dummy_slots (dummy_slots_q),
		.status      (status),
		.res_valid   (res_valid),
		.res_data    (res_data),
		.res_ready   (result.ready)
	);

	// Result channel.
	assign result.valid = res_valid;
	assign result.bucket_index = res_data.bucket_index;
	assign result.slot_offset = res_data.slot_offset;
	assign result.real_hit = res_data.real_hit;
	assign result.no_slot = res_data.no_slot;
	assign result.reshuffle_needed = res_data.reshuffle_needed;
	assign result.visit_count = res_data.visit_count;

endmodule

[hdl/obst_checker.sv]
`include "oram_bucket_slot_tracker_assert.svh"

module obst_checker import obst_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [BKT_W-1:0]      out_bucket_index,
	input logic [SLOT_W-1:0]     out_slot_offset,
	input logic                  out_real_hit,
	input logic                  out_no_slot,
	input logic                  out_reshuffle_needed,
	input logic [CNT_W-1:0]      out_visit_count
);

	logic [CNT_W-1:0] dummy_q;
	result_t          out_pay;

	assign out_pay = {out_bucket_index, out_slot_offset, out_real_hit, out_no_slot,
		out_reshuffle_needed, out_visit_count};

	// Shadow of the reshuffle threshold as seen on the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dummy_q <= DUMMY_SLOTS_RST;
		end else if (cfg_valid && cfg_ready && (cfg_index == REG_DUMMY_SLOTS)) begin
			dummy_q <= cfg_data[CNT_W-1:0];
		end
	end

	// A stalled result keeps its value.
	`OBST_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_pay))

	// A hit is never reported together with a missing slot.
	`OBST_ASSERT_SAME(a_hit_excl, clk, arst_n, out_valid && out_real_hit, !out_no_slot)

	// The reshuffle flag follows the reported count and the threshold.
	`OBST_ASSERT_SAME(a_reshuffle, clk, arst_n, out_valid && !out_no_slot, out_reshuffle_needed == (out_visit_count >= dummy_q))

endmodule

bind oram_bucket_slot_tracker obst_checker u_obst_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.cfg_valid            (cfg.valid),
	.cfg_ready            (cfg.ready),
	.cfg_index            (cfg.index),
	.cfg_data             (cfg.data),
	.out_valid            (result.valid),
	.out_ready            (result.ready),
	.out_bucket_index     (result.bucket_index),
	.out_slot_offset      (result.slot_offset),
	.out_real_hit         (result.real_hit),
	.out_no_slot          (result.no_slot),
	.out_reshuffle_needed (result.reshuffle_needed),
	.out_visit_count      (result.visit_count)
);
